[hw/rtl/pkic_pkg.sv]
// shared widths, constants, codes and control structs of the interval coalescer
`default_nettype none

package pkic_pkg;

  // fixed field widths
  localparam int KEY_IN_W   = 5;
  localparam int CHROM_W    = 16;
  localparam int POS_W      = 32;
  localparam int SCORE_W    = 16;
  localparam int STATUS_W   = 8;
  localparam int CFG_W      = 20;

  // register port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // most results one flush may produce
  localparam int MAX_RESULTS = 32;
  localparam int CNT_W       = $clog2(MAX_RESULTS);

  // register reset values
  localparam logic [CFG_W-1:0] MERGE_GAP_RESET = 20'd500;
  localparam logic [CFG_W-1:0] MIN_SIZE_RESET  = 20'd10000;

  // operation codes
  localparam logic OP_INTERVAL = 1'b0;
  localparam logic OP_FLUSH    = 1'b1;

  // register index, taken from address bit 2
  localparam logic REG_MERGE_GAP = 1'b0;
  localparam logic REG_MIN_SIZE  = 1'b1;

  // source of an emitted result
  typedef enum logic [1:0] {
    SRC_CUR,
    SRC_PEND_KEY,
    SRC_PEND_SCAN
  } emit_src_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic      load_req;
    logic      rd_key;
    logic      rd_scan;
    logic      mul;
    logic      div_init;
    logic      div_step;
    logic      apply_merge;
    logic      clr_key;
    logic      clr_scan;
    logic      pend_write;
    logic      scan_init;
    logic      scan_step;
    logic      out_load;
    logic      out_last;
    emit_src_t out_src;
  } dp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic op_flush;
    logic key_ok;
    logic key_valid;
    logic merge_hit;
    logic cur_emit;
    logic scan_valid;
    logic scan_end;
    logic more_after;
    logic count_full;
    logic div_done;
    logic out_ready;
  } dp_sts_t;

endpackage

`default_nettype wire

[hw/rtl/pkic_ram.sv]
// generic single write port memory with registered read
`default_nettype none

module pkic_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/pkic_ctrl.sv]
// controller state machine of the interval coalescer
`default_nettype none

module pkic_ctrl import pkic_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    req_valid,
  output logic         req_stall,
  output dp_cmd_t      cmd,
  input  wire dp_sts_t sts
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LOOKUP,
    ST_DIV_INIT,
    ST_DIV,
    ST_MERGE,
    ST_EMIT_PEND,
    ST_CUR,
    ST_SCAN,
    ST_SCAN_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   scan_last;

  // a flush result is final when nothing pending lies above it or the limit is hit
  assign scan_last = !sts.more_after || sts.count_full;

  // new request only taken while idle
  assign req_stall = (state != ST_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts.op_flush) begin
          cmd.scan_init = 1'b1;
          state_next    = ST_SCAN;
        end else if (!sts.key_ok) begin
          state_next = ST_IDLE;
        end else if (sts.key_valid) begin
          cmd.rd_key = 1'b1;
          state_next = ST_LOOKUP;
        end else begin
          state_next = ST_CUR;
        end
      end
      ST_LOOKUP: begin
        if (sts.merge_hit) begin
          cmd.mul    = 1'b1;
          state_next = ST_DIV_INIT;
        end else begin
          state_next = ST_EMIT_PEND;
        end
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_next = ST_MERGE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_MERGE: begin
        cmd.apply_merge = 1'b1;
        cmd.clr_key     = 1'b1;
        state_next      = ST_CUR;
      end
      ST_EMIT_PEND: begin
        if (sts.out_ready) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = SRC_PEND_KEY;
          cmd.out_last = !sts.cur_emit;
          cmd.clr_key  = 1'b1;
          state_next   = ST_CUR;
        end
      end
      ST_CUR: begin
        if (sts.cur_emit) begin
          if (sts.out_ready) begin
            cmd.out_load = 1'b1;
            cmd.out_src  = SRC_CUR;
            cmd.out_last = 1'b1;
            state_next   = ST_IDLE;
          end
        end else begin
          cmd.pend_write = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (sts.scan_valid) begin
          cmd.rd_scan = 1'b1;
          state_next  = ST_SCAN_EMIT;
        end else if (sts.scan_end) begin
          state_next = ST_IDLE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_SCAN_EMIT: begin
        if (sts.out_ready) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = SRC_PEND_SCAN;
          cmd.out_last = scan_last;
          cmd.clr_scan = 1'b1;
          if (scan_last) begin
            state_next = ST_IDLE;
          end else begin
            cmd.scan_step = 1'b1;
            state_next    = ST_SCAN;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/pkic_dp.sv]
// datapath: request register, pending store, merge arithmetic and result register
`default_nettype none

module pkic_dp import pkic_pkg::*; #(
  parameter int NUM_KEYS   = 32,
  parameter int SCORE_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire dp_cmd_t             cmd,
  output dp_sts_t                  sts,
  input  wire logic [CFG_W-1:0]    merge_gap,
  input  wire logic [CFG_W-1:0]    min_size,
  input  wire logic                op,
  input  wire logic [KEY_IN_W-1:0] species,
  input  wire logic [CHROM_W-1:0]  chrom,
  input  wire logic [POS_W-1:0]    start_req,
  input  wire logic [POS_W-1:0]    stop,
  input  wire logic [SCORE_W-1:0]  score,
  input  wire logic [STATUS_W-1:0] left_status,
  input  wire logic [STATUS_W-1:0] right_status,
  output logic                     rsp_valid,
  input  wire logic                rsp_stall,
  output logic [KEY_IN_W-1:0]      out_species,
  output logic [CHROM_W-1:0]       out_chrom,
  output logic [POS_W-1:0]         out_start,
  output logic [POS_W-1:0]         out_stop,
  output logic [SCORE_W-1:0]       out_score,
  output logic [STATUS_W-1:0]      out_left_status,
  output logic [STATUS_W-1:0]      out_right_status,
  output logic                     last
);

  localparam int KEY_W  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int PROD_W = SCORE_BITS + POS_W;
  localparam int NUM_W  = PROD_W + 1;
  localparam int DCNT_W = $clog2(NUM_W + 1);

  typedef struct packed {
    logic [CHROM_W-1:0]    chrom;
    logic [POS_W-1:0]      start;
    logic [POS_W-1:0]      stop;
    logic [SCORE_BITS-1:0] score;
    logic [STATUS_W-1:0]   left;
    logic [STATUS_W-1:0]   right;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);

  // held request
  logic                  cur_op;
  logic [KEY_IN_W-1:0]   cur_key;
  logic [CHROM_W-1:0]    cur_chrom;
  logic [POS_W-1:0]      cur_start;
  logic [POS_W-1:0]      cur_stop;
  logic [SCORE_BITS-1:0] cur_score;
  logic [STATUS_W-1:0]   cur_left;
  logic [STATUS_W-1:0]   cur_right;

  // pending store control and flush walk
  logic [NUM_KEYS-1:0]   pend_valid;
  logic [KEY_W-1:0]      scan_idx;
  logic [CNT_W-1:0]      emit_cnt;

  // merge arithmetic
  logic [PROD_W-1:0]     prod_p;
  logic [PROD_W-1:0]     prod_c;
  logic [POS_W-1:0]      den;
  logic [NUM_W-1:0]      quo;
  logic [POS_W-1:0]      rem;
  logic [DCNT_W-1:0]     div_cnt;

  // memory port signals
  logic [KEY_W-1:0]      key_addr;
  logic [KEY_W-1:0]      ram_raddr;
  logic [ENT_W-1:0]      ram_rdata;
  logic [ENT_W-1:0]      ram_wdata;
  ent_t                  pend_ent;
  ent_t                  cur_ent;

  logic                  key_ok;
  logic [POS_W+1:0]      gap;
  logic [POS_W-1:0]      span_c;
  logic [POS_W-1:0]      span_p;
  logic [POS_W:0]        trial;
  logic                  trial_ge;
  logic [SCORE_BITS-1:0] merged_score;
  logic [NUM_KEYS-1:0]   above;
  logic                  out_ready;

  assign key_ok   = (32'(cur_key) < 32'(NUM_KEYS));
  assign key_addr = KEY_W'(cur_key);

  assign cur_ent.chrom = cur_chrom;
  assign cur_ent.start = cur_start;
  assign cur_ent.stop  = cur_stop;
  assign cur_ent.score = cur_score;
  assign cur_ent.left  = cur_left;
  assign cur_ent.right = cur_right;
  assign ram_wdata     = cur_ent;
  assign pend_ent      = ent_t'(ram_rdata);
  assign ram_raddr     = cmd.rd_scan ? scan_idx : key_addr;

  // pending entries, one row per key
  pkic_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_KEYS)
  ) u_pend_ram (
    .clk   (clk),
    .we    (cmd.pend_write),
    .waddr (key_addr),
    .wdata (ram_wdata),
    .re    (cmd.rd_key || cmd.rd_scan),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // capture request, score masked to its stored width, or apply a merge to start, score and left status
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      cur_op    <= op;
      cur_key   <= species;
      cur_chrom <= chrom;
      cur_start <= start_req;
      cur_stop  <= stop;
      cur_score <= SCORE_BITS'(score);
      cur_left  <= left_status;
      cur_right <= right_status;
    end else if (cmd.apply_merge) begin
      cur_start <= pend_ent.start;
      cur_score <= merged_score;
      cur_left  <= pend_ent.left;
    end
  end

  // signed gap between new start and pending end
  assign gap    = {2'b00, cur_start} + 34'd1 - {2'b00, pend_ent.stop};
  assign span_c = cur_stop - cur_start;
  assign span_p = pend_ent.stop - pend_ent.start;

  // weighted score products and merged span
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_p <= PROD_W'(pend_ent.score) * PROD_W'(span_p);
      prod_c <= PROD_W'(cur_score) * PROD_W'(span_c);
      den    <= cur_stop - pend_ent.start;
    end
  end

  // restoring division, one quotient bit a cycle
  assign trial    = {rem, quo[NUM_W-1]};
  assign trial_ge = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      quo     <= {1'b0, prod_p} + {1'b0, prod_c};
      rem     <= '0;
      div_cnt <= DCNT_W'(NUM_W);
    end else if (cmd.div_step) begin
      rem     <= trial_ge ? POS_W'(trial - {1'b0, den}) : trial[POS_W-1:0];
      quo     <= {quo[NUM_W-2:0], trial_ge};
      div_cnt <= div_cnt - DCNT_W'(1);
    end
  end

  // zero span gives zero, large quotient saturates
  always_comb begin
    if (den == '0) begin
      merged_score = '0;
    end else if (|quo[NUM_W-1:SCORE_BITS]) begin
      merged_score = '1;
    end else begin
      merged_score = quo[SCORE_BITS-1:0];
    end
  end

  // valid bits of the pending store
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= '0;
    end else begin
      if (cmd.pend_write) begin
        pend_valid[key_addr] <= 1'b1;
      end
      if (cmd.clr_key) begin
        pend_valid[key_addr] <= 1'b0;
      end
      if (cmd.clr_scan) begin
        pend_valid[scan_idx] <= 1'b0;
      end
    end
  end

  // flush walk index and result count
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      scan_idx <= '0;
      emit_cnt <= '0;
    end else begin
      if (cmd.scan_step) begin
        scan_idx <= scan_idx + KEY_W'(1);
      end
      if (cmd.clr_scan) begin
        emit_cnt <= emit_cnt + CNT_W'(1);
      end
    end
  end

  // pending keys above the walk position
  always_comb begin
    for (int j = 0; j < NUM_KEYS; j++) begin
      above[j] = pend_valid[j] && (KEY_W'(j) > scan_idx);
    end
  end

  // result register, free when empty or being taken
  assign out_ready = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      last <= cmd.out_last;
      case (cmd.out_src)
        SRC_CUR: begin
          out_species      <= cur_key;
          out_chrom        <= cur_chrom;
          out_start        <= cur_start;
          out_stop         <= cur_stop;
          out_score        <= SCORE_W'(cur_score);
          out_left_status  <= cur_left;
          out_right_status <= cur_right;
        end
        SRC_PEND_KEY, SRC_PEND_SCAN: begin
          out_species      <= (cmd.out_src == SRC_PEND_KEY) ? cur_key
                                                            : KEY_IN_W'(scan_idx);
          out_chrom        <= pend_ent.chrom;
          out_start        <= pend_ent.start;
          out_stop         <= pend_ent.stop;
          out_score        <= SCORE_W'(pend_ent.score);
          out_left_status  <= pend_ent.left;
          out_right_status <= pend_ent.right;
        end
        default: begin
          out_species      <= cur_key;
          out_chrom        <= cur_chrom;
          out_start        <= cur_start;
          out_stop         <= cur_stop;
          out_score        <= SCORE_W'(cur_score);
          out_left_status  <= cur_left;
          out_right_status <= cur_right;
        end
      endcase
    end
  end

  // status to the controller
  assign sts.op_flush   = (cur_op == OP_FLUSH);
  assign sts.key_ok     = key_ok;
  assign sts.key_valid  = key_ok && pend_valid[key_addr];
  assign sts.merge_hit  = (pend_ent.chrom == cur_chrom) &&
                          ($signed(gap) < $signed({14'd0, merge_gap}));
  assign sts.cur_emit   = (span_c > {12'd0, min_size});
  assign sts.scan_valid = pend_valid[scan_idx];
  assign sts.scan_end   = (scan_idx == KEY_W'(NUM_KEYS - 1));
  assign sts.more_after = |above;
  assign sts.count_full = (emit_cnt == CNT_W'(MAX_RESULTS - 1));
  assign sts.div_done   = (div_cnt == '0);
  assign sts.out_ready  = out_ready;

  // a result is loaded only into a free result register
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_ready)
    else $error("result loaded over an unaccepted result");

  // a pending write targets a real key whose slot is empty
  a_write_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.pend_write |-> (key_ok && !pend_valid[key_addr]))
    else $error("pending entry overwritten");

  // no division step beyond the quotient width
  a_div_count: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (div_cnt != '0))
    else $error("division stepped past its end");

  // flush only clears entries that are pending
  a_scan_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_scan |-> pend_valid[scan_idx])
    else $error("flush emitted an empty entry");

endmodule

`default_nettype wire

[hw/rtl/per_key_interval_coalescer.sv]
// top level: register port, controller and datapath of the interval coalescer
// a request with no pending entry for its key is decoded, then emitted or stored as pending
// a merge adds a pending store read, a multiply, a restoring division and an update
// a flush walks the keys in order and emits each pending entry, up to MAX_RESULTS results
// throughput: one request at a time; the result register lets the next request in
// reset clears all pending entries and loads merge_gap 500 and min_size 10000
`default_nettype none

module per_key_interval_coalescer import pkic_pkg::*; #(
  parameter int NUM_KEYS   = 32,
  parameter int SCORE_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // request channel
  input  wire logic                  req_valid,
  output logic                       req_stall,
  input  wire logic                  op,
  input  wire logic [KEY_IN_W-1:0]   species,
  input  wire logic [CHROM_W-1:0]    chrom,
  input  wire logic [POS_W-1:0]      start_req,
  input  wire logic [POS_W-1:0]      stop,
  input  wire logic [SCORE_W-1:0]    score,
  input  wire logic [STATUS_W-1:0]   left_status,
  input  wire logic [STATUS_W-1:0]   right_status,
  // result channel
  output logic                       rsp_valid,
  input  wire logic                  rsp_stall,
  output logic [KEY_IN_W-1:0]        out_species,
  output logic [CHROM_W-1:0]         out_chrom,
  output logic [POS_W-1:0]           out_start,
  output logic [POS_W-1:0]           out_stop,
  output logic [SCORE_W-1:0]         out_score,
  output logic [STATUS_W-1:0]        out_left_status,
  output logic [STATUS_W-1:0]        out_right_status,
  output logic                       last,
  // register port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready
);

  logic [CFG_W-1:0] merge_gap;
  logic [CFG_W-1:0] min_size;
  logic             cfg_write;
  dp_cmd_t          cmd;
  dp_sts_t          sts;

  // register port, always ready
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      merge_gap <= MERGE_GAP_RESET;
      min_size  <= MIN_SIZE_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_MERGE_GAP: merge_gap <= pwdata[CFG_W-1:0];
        REG_MIN_SIZE:  min_size  <= pwdata[CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // register read back
  always_comb begin
    case (paddr[2])
      REG_MERGE_GAP: prdata = APB_DATA_W'(merge_gap);
      REG_MIN_SIZE:  prdata = APB_DATA_W'(min_size);
      default:       prdata = '0;
    endcase
  end

  pkic_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  pkic_dp #(
    .NUM_KEYS   (NUM_KEYS),
    .SCORE_BITS (SCORE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .merge_gap        (merge_gap),
    .min_size         (min_size),
    .op               (op),
    .species          (species),
    .chrom            (chrom),
    .start_req        (start_req),
    .stop             (stop),
    .score            (score),
    .left_status      (left_status),
    .right_status     (right_status),
    .rsp_valid        (rsp_valid),
    .rsp_stall        (rsp_stall),
    .out_species      (out_species),
    .out_chrom        (out_chrom),
    .out_start        (out_start),
    .out_stop         (out_stop),
    .out_score        (out_score),
    .out_left_status  (out_left_status),
    .out_right_status (out_right_status),
    .last             (last)
  );

endmodule

`default_nettype wire

[tb/pkic_checker.sv]
// watcher of the interval coalescer: predicts emitted intervals per request and compares them
`default_nettype none

module pkic_checker import pkic_pkg::*; #(
  parameter int NUM_KEYS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  req_valid,
  input  wire logic                  req_stall,
  input  wire logic                  op,
  input  wire logic [KEY_IN_W-1:0]   species,
  input  wire logic [CHROM_W-1:0]    chrom,
  input  wire logic [POS_W-1:0]      start_req,
  input  wire logic [POS_W-1:0]      stop,
  input  wire logic [SCORE_W-1:0]    score,
  input  wire logic [STATUS_W-1:0]   left_status,
  input  wire logic [STATUS_W-1:0]   right_status,
  input  wire logic                  rsp_valid,
  input  wire logic                  rsp_stall,
  input  wire logic [KEY_IN_W-1:0]   out_species,
  input  wire logic [CHROM_W-1:0]    out_chrom,
  input  wire logic [POS_W-1:0]      out_start,
  input  wire logic [POS_W-1:0]      out_stop,
  input  wire logic [SCORE_W-1:0]    out_score,
  input  wire logic [STATUS_W-1:0]   out_left_status,
  input  wire logic [STATUS_W-1:0]   out_right_status,
  input  wire logic                  last,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  input  wire logic [APB_DATA_W-1:0] prdata,
  input  wire logic                  pready,
  output int                         fail_count,
  output int                         awaiting,
  output int                         n_requests,
  output int                         n_results,
  output int                         n_merges
);

  // one scored interval, as held per key or as emitted
  typedef struct packed {
    logic [KEY_IN_W-1:0] key;
    logic [CHROM_W-1:0]  chrom;
    logic [POS_W-1:0]    lo;
    logic [POS_W-1:0]    hi;
    logic [SCORE_W-1:0]  score;
    logic [STATUS_W-1:0] lstat;
    logic [STATUS_W-1:0] rstat;
    logic                fin;
  } iv_t;

  localparam logic [SCORE_W-1:0] SCORE_TOP = '1;

  logic [CFG_W-1:0] gap_limit = MERGE_GAP_RESET;
  logic [CFG_W-1:0] emit_size = MIN_SIZE_RESET;
  iv_t              held [NUM_KEYS];
  logic             held_ok [NUM_KEYS];
  iv_t              emitted_q [$];
  int               mism = 0;
  int               reqs = 0;
  int               outs = 0;
  int               merges = 0;

  initial begin
    fail_count = 0;
    awaiting   = 0;
    n_requests = 0;
    n_results  = 0;
    n_merges   = 0;
  end

  task automatic report(input string what, input longint unsigned want,
                        input longint unsigned got);
    mism++;
    if (mism <= 40)
      $display("mismatch at %0t: %s expected 0x%0h got 0x%0h", $time, what, want, got);
  endtask

  // coalesce one request against the held intervals, queue what it emits
  task automatic coalesce_request(input iv_t cur, input logic is_flush);
    iv_t              batch [$];
    iv_t              tail;
    longint           gap;
    logic [POS_W-1:0] span_h;
    logic [POS_W-1:0] span_c;
    logic [POS_W-1:0] den;
    logic [63:0]      num;
    logic [63:0]      q;
    if (is_flush) begin
      // walk keys in ascending order
      for (int i = 0; i < NUM_KEYS; i++) begin
        if (held_ok[i] && batch.size() < MAX_RESULTS) begin
          batch.push_back(held[i]);
          held_ok[i] = 1'b0;
        end
      end
    end else begin
      if (held_ok[cur.key]) begin
        gap = longint'({32'd0, cur.lo}) + 1 - longint'({32'd0, held[cur.key].hi});
        if (held[cur.key].chrom == cur.chrom && gap < longint'(gap_limit)) begin
          // length-weighted score over the joined span, truncated and saturated
          span_h = held[cur.key].hi - held[cur.key].lo;
          span_c = cur.hi - cur.lo;
          num = 64'(held[cur.key].score) * 64'(span_h) + 64'(cur.score) * 64'(span_c);
          den = cur.hi - held[cur.key].lo;
          q = (den == '0) ? 64'd0 : num / 64'(den);
          if (q > 64'(SCORE_TOP))
            q = 64'(SCORE_TOP);
          cur.score = q[SCORE_W-1:0];
          cur.lo    = held[cur.key].lo;
          cur.lstat = held[cur.key].lstat;
          merges++;
        end else begin
          batch.push_back(held[cur.key]);
        end
        held_ok[cur.key] = 1'b0;
      end
      // long enough to go out now, else held for its key
      span_c = cur.hi - cur.lo;
      if (span_c > {{(POS_W-CFG_W){1'b0}}, emit_size}) begin
        batch.push_back(cur);
      end else begin
        held[cur.key]    = cur;
        held_ok[cur.key] = 1'b1;
      end
    end
    if (batch.size() > 0) begin
      tail = batch.pop_back();
      tail.fin = 1'b1;
      batch.push_back(tail);
    end
    foreach (batch[i])
      emitted_q.push_back(batch[i]);
  endtask

  always @(posedge clk) begin
    iv_t got;
    iv_t want;
    if (rst) begin
      gap_limit = MERGE_GAP_RESET;
      emit_size = MIN_SIZE_RESET;
      foreach (held_ok[i])
        held_ok[i] = 1'b0;
      emitted_q.delete();
    end else begin
      // register port: track writes, check reads
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_MIN_SIZE)
            emit_size = pwdata[CFG_W-1:0];
          else
            gap_limit = pwdata[CFG_W-1:0];
        end else begin
          want.lo = (paddr[2] == REG_MIN_SIZE) ? POS_W'(emit_size) : POS_W'(gap_limit);
          if (prdata !== want.lo)
            report("register read", want.lo, prdata);
        end
      end
      // accepted request
      if (req_valid && !req_stall) begin
        reqs++;
        coalesce_request('{species, chrom, start_req, stop, score, left_status,
                           right_status, 1'b0}, op == OP_FLUSH);
      end
      // accepted result against the oldest expectation
      if (rsp_valid && !rsp_stall) begin
        outs++;
        got = '{out_species, out_chrom, out_start, out_stop, out_score, out_left_status,
                out_right_status, last};
        if (emitted_q.size() == 0) begin
          report("result with none awaited, out_start", 0, got.lo);
        end else begin
          want = emitted_q.pop_front();
          if (got.key !== want.key)     report("out_species", want.key, got.key);
          if (got.chrom !== want.chrom) report("out_chrom", want.chrom, got.chrom);
          if (got.lo !== want.lo)       report("out_start", want.lo, got.lo);
          if (got.hi !== want.hi)       report("out_stop", want.hi, got.hi);
          if (got.score !== want.score) report("out_score", want.score, got.score);
          if (got.lstat !== want.lstat) report("out_left_status", want.lstat, got.lstat);
          if (got.rstat !== want.rstat) report("out_right_status", want.rstat, got.rstat);
          if (got.fin !== want.fin)     report("last", want.fin, got.fin);
        end
      end
    end
    fail_count <= mism;
    awaiting   <= emitted_q.size();
    n_requests <= reqs;
    n_results  <= outs;
    n_merges   <= merges;
  end

endmodule

`default_nettype wire

[tb/tb_per_key_interval_coalescer.sv]
// testbench top: request, register and back-pressure stimulus for the interval coalescer
`default_nettype none

module tb_per_key_interval_coalescer;
  import pkic_pkg::*;

  localparam int LIMIT = 400000;

  // one request as offered on the request channel
  typedef struct packed {
    logic                op;
    logic [KEY_IN_W-1:0] key;
    logic [CHROM_W-1:0]  chrom;
    logic [POS_W-1:0]    lo;
    logic [POS_W-1:0]    hi;
    logic [SCORE_W-1:0]  score;
    logic [STATUS_W-1:0] lstat;
    logic [STATUS_W-1:0] rstat;
  } req_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  logic                  op = OP_INTERVAL;
  logic [KEY_IN_W-1:0]   species = '0;
  logic [CHROM_W-1:0]    chrom = '0;
  logic [POS_W-1:0]      start_req = '0;
  logic [POS_W-1:0]      stop = '0;
  logic [SCORE_W-1:0]    score = '0;
  logic [STATUS_W-1:0]   left_status = '0;
  logic [STATUS_W-1:0]   right_status = '0;
  logic                  rsp_valid;
  logic                  rsp_stall = 1'b0;
  logic [KEY_IN_W-1:0]   out_species;
  logic [CHROM_W-1:0]    out_chrom;
  logic [POS_W-1:0]      out_start;
  logic [POS_W-1:0]      out_stop;
  logic [SCORE_W-1:0]    out_score;
  logic [STATUS_W-1:0]   out_left_status;
  logic [STATUS_W-1:0]   out_right_status;
  logic                  last;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int fail_count;
  int awaiting;
  int n_requests;
  int n_results;
  int n_merges;
  int cycle_count = 0;

  // pacing controls
  logic calm = 1'b0;
  logic hold_go = 1'b0;
  logic hold_spent = 1'b0;
  int   hold_left = 0;

  // register values as last written, for shaping the random intervals
  logic [CFG_W-1:0] gap_now = MERGE_GAP_RESET;
  logic [CFG_W-1:0] min_now = MIN_SIZE_RESET;

  // per-key running position for chained intervals
  logic [CHROM_W-1:0] lane_chrom [32];
  logic [POS_W-1:0]   lane_end [32];
  bit                 lane_used [32];

  always #10 clk = ~clk;

  per_key_interval_coalescer u_top (
    .clk              (clk),
    .rst              (rst),
    .req_valid        (req_valid),
    .req_stall        (req_stall),
    .op               (op),
    .species          (species),
    .chrom            (chrom),
    .start_req        (start_req),
    .stop             (stop),
    .score            (score),
    .left_status      (left_status),
    .right_status     (right_status),
    .rsp_valid        (rsp_valid),
    .rsp_stall        (rsp_stall),
    .out_species      (out_species),
    .out_chrom        (out_chrom),
    .out_start        (out_start),
    .out_stop         (out_stop),
    .out_score        (out_score),
    .out_left_status  (out_left_status),
    .out_right_status (out_right_status),
    .last             (last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  pkic_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .req_valid        (req_valid),
    .req_stall        (req_stall),
    .op               (op),
    .species          (species),
    .chrom            (chrom),
    .start_req        (start_req),
    .stop             (stop),
    .score            (score),
    .left_status      (left_status),
    .right_status     (right_status),
    .rsp_valid        (rsp_valid),
    .rsp_stall        (rsp_stall),
    .out_species      (out_species),
    .out_chrom        (out_chrom),
    .out_start        (out_start),
    .out_stop         (out_stop),
    .out_score        (out_score),
    .out_left_status  (out_left_status),
    .out_right_status (out_right_status),
    .last             (last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .fail_count       (fail_count),
    .awaiting         (awaiting),
    .n_requests       (n_requests),
    .n_results        (n_results),
    .n_merges         (n_merges)
  );

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("timeout after %0d cycles, %0d results still awaited", LIMIT, awaiting);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off, calm stretch
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_go && !hold_spent) begin
      hold_left  <= 400;
      hold_spent <= 1'b1;
      rsp_stall  <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= !calm && ($urandom_range(99) < 16);
    end
  end

  // present one request until taken, then maybe leave a gap
  task automatic offer(input req_t r);
    req_valid    <= 1'b1;
    op           <= r.op;
    species      <= r.key;
    chrom        <= r.chrom;
    start_req    <= r.lo;
    stop         <= r.hi;
    score        <= r.score;
    left_status  <= r.lstat;
    right_status <= r.rstat;
    do @(posedge clk); while (req_stall);
    if (!calm && $urandom_range(99) < 16) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_interval(input int k, input logic [CHROM_W-1:0] ch,
                               input logic [POS_W-1:0] lo, input logic [POS_W-1:0] hi,
                               input logic [SCORE_W-1:0] sc,
                               input logic [STATUS_W-1:0] ls, input logic [STATUS_W-1:0] rs);
    offer('{OP_INTERVAL, KEY_IN_W'(k), ch, lo, hi, sc, ls, rs});
  endtask

  task automatic flush_all();
    req_t r;
    r = '{OP_FLUSH, KEY_IN_W'($urandom), CHROM_W'($urandom), POS_W'($urandom),
          POS_W'($urandom), SCORE_W'($urandom), STATUS_W'($urandom), STATUS_W'($urandom)};
    offer(r);
  endtask

  // register access: setup cycle then access cycle
  task automatic reg_access(input logic wr, input logic idx, input logic [CFG_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= APB_DATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (wr && idx == REG_MIN_SIZE)
      min_now = val;
    else if (wr)
      gap_now = val;
  endtask

  task automatic set_config(input logic [CFG_W-1:0] gap, input logic [CFG_W-1:0] minsz);
    reg_access(1'b1, REG_MERGE_GAP, gap);
    reg_access(1'b1, REG_MIN_SIZE, minsz);
    reg_access(1'b0, REG_MERGE_GAP, '0);
    reg_access(1'b0, REG_MIN_SIZE, '0);
  endtask

  // drain: all results in, then room for a walk or merge that emits nothing
  task automatic settle();
    req_valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
    repeat (150) @(posedge clk);
  endtask

  // mostly chained intervals per key near the merge window, some flushes and noise
  task automatic make_item(output req_t r);
    int          pick;
    int          k;
    int          off;
    int unsigned span;
    int unsigned cap;
    pick = $urandom_range(99);
    r = '{OP_INTERVAL, KEY_IN_W'($urandom), CHROM_W'($urandom), POS_W'($urandom),
          POS_W'($urandom), SCORE_W'($urandom), STATUS_W'($urandom), STATUS_W'($urandom)};
    if (pick < 6) begin
      r.op = OP_FLUSH;
    end else if (pick < 80) begin
      k = ($urandom_range(9) < 7) ? $urandom_range(7) : $urandom_range(31);
      if (!lane_used[k] || $urandom_range(11) == 0) begin
        lane_chrom[k] = CHROM_W'($urandom);
        lane_end[k]   = $urandom;
        lane_used[k]  = 1'b1;
      end
      off  = ($urandom_range(3) == 0) ? -int'($urandom_range(300))
                                     : int'($urandom_range(gap_now + 20));
      cap  = (min_now > 4000) ? 4000 : min_now;
      span = ($urandom_range(3) == 0) ? min_now + $urandom_range(2000) : $urandom_range(cap);
      r.key   = KEY_IN_W'(k);
      r.chrom = lane_chrom[k];
      r.lo    = lane_end[k] + off;
      r.hi    = r.lo + span;
      lane_end[k] = r.hi;
    end
  endtask

  task automatic run_random(input int count, input logic pressure);
    req_t r;
    for (int i = 0; i < count; i++) begin
      if (pressure && i == 20) hold_go <= 1'b1;
      if (pressure && i == 45) calm <= 1'b1;
      if (pressure && i == 85) calm <= 1'b0;
      make_item(r);
      offer(r);
    end
    flush_all();
    settle();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // reset values read back
    reg_access(1'b0, REG_MERGE_GAP, '0);
    reg_access(1'b0, REG_MIN_SIZE, '0);

    // directed: empty flush, merges forward and backward, chrom change
    flush_all();
    send_interval(0, 16'h0000, 32'd0, 32'd100, 16'h0000, 8'h00, 8'h00);
    send_interval(0, 16'h0000, 32'd150, 32'd300, 16'hFFFF, 8'h01, 8'h02);
    send_interval(0, 16'h0000, 32'd50, 32'd250, 16'h8000, 8'h03, 8'h04);
    send_interval(0, 16'h0001, 32'd1000, 32'd1100, 16'h1234, 8'h05, 8'h06);
    // wrapped span, far gap, zero joined span
    send_interval(31, 16'hFFFF, 32'hFFFF_FFF0, 32'h0000_0010, 16'hABCD, 8'hFF, 8'h00);
    send_interval(31, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'h00, 8'hFF);
    send_interval(31, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h7777, 8'hAA, 8'h55);
    send_interval(5, 16'hFFFF, 32'd0, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 8'hFF);
    // saturating merged score, then gap just inside and just at the limit
    send_interval(7, 16'h0002, 32'd1000, 32'd1100, 16'hFFFF, 8'h10, 8'h11);
    send_interval(7, 16'h0002, 32'd0, 32'd1001, 16'hFFFF, 8'h12, 8'h13);
    send_interval(7, 16'h0002, 32'd1499, 32'd1600, 16'h4000, 8'h14, 8'h15);
    send_interval(7, 16'h0002, 32'd2099, 32'd2200, 16'h0001, 8'h16, 8'h17);
    // span at and just above the emit size, merge that goes out at once
    send_interval(9, 16'h0003, 32'd0, 32'd10000, 16'h0100, 8'h20, 8'h21);
    send_interval(10, 16'h0003, 32'd0, 32'd10001, 16'h0200, 8'h22, 8'h23);
    send_interval(9, 16'h0003, 32'd10000, 32'd10001, 16'hF000, 8'h24, 8'h25);
    flush_all();
    flush_all();
    settle();

    // random phases over several register settings
    run_random(90, 1'b1);
    set_config('0, '0);
    run_random(50, 1'b0);
    set_config('1, '1);
    run_random(60, 1'b0);
    set_config(CFG_W'($urandom_range(1, 2000)), CFG_W'($urandom_range(100, 20000)));
    run_random(70, 1'b0);

    $display("run covered %0d requests and %0d checked results, %0d of them merges,",
             n_requests, n_results, n_merges);
    $display("over reset, zero, full-scale and random gap and size settings");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
